// File: sv/cia_pkg.sv
package cia_pkg;

    // Operand and half-word widths.
    localparam int DATA_W = 64;
    localparam int HALF_W = 32;

    // Operation codes carried on the cmd field.
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_NEG = 2'd2,
        CMD_MUL = 2'd3
    } t_cmd;

    // Results of the operand preparation stage.
    typedef struct packed {
        logic              sgn;
        logic [DATA_W-1:0] arith_r;
        logic              arith_ovf;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic              neg;
    } t_front;

    // Fields that travel alongside the multiplier stages.
    typedef struct packed {
        logic              wide;
        logic              sgn;
        logic              is_mul;
        logic              clr;
        logic [DATA_W-1:0] arith_r;
        logic              arith_ovf;
        logic              neg;
    } t_side;

    // Load enables for the multiplier stages.
    typedef struct packed {
        logic ld_pp;
        logic ld_sum;
    } t_mul_en;

endpackage

// File: sv/cia_front.sv
module cia_front (
    input  cia_pkg::t_cmd                 i_cmd,
    input  logic                          i_is_signed,
    input  logic                          i_is_wide,
    input  logic [cia_pkg::DATA_W-1:0]    i_operand_a,
    input  logic [cia_pkg::DATA_W-1:0]    i_operand_b,
    output cia_pkg::t_front               o_front
);
    import cia_pkg::*;

    logic              sgn;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic              cin;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] r;
    logic              carry;
    logic              vflag;
    logic              ovf_wide;
    logic              ovf_narrow;

    // Negate is always a signed operation.
    assign sgn = i_is_signed || (i_cmd == CMD_NEG);

    // In 32-bit mode the low halves are sign or zero extended to full width,
    // so that the full-width arithmetic below is exact.
    always_comb begin
        if (i_is_wide) begin
            x = i_operand_a;
            y = i_operand_b;
        end else if (sgn) begin
            x = {{HALF_W{i_operand_a[HALF_W-1]}}, i_operand_a[HALF_W-1:0]};
            y = {{HALF_W{i_operand_b[HALF_W-1]}}, i_operand_b[HALF_W-1:0]};
        end else begin
            x = {{HALF_W{1'b0}}, i_operand_a[HALF_W-1:0]};
            y = {{HALF_W{1'b0}}, i_operand_b[HALF_W-1:0]};
        end
    end

    // One shared adder serves add, subtract and negate.
    always_comb begin
        unique case (i_cmd)
            CMD_ADD: begin
                lhs = x;
                rhs = y;
                cin = 1'b0;
            end
            CMD_NEG: begin
                lhs = '0;
                rhs = ~x;
                cin = 1'b1;
            end
            default: begin
                lhs = x;
                rhs = ~y;
                cin = 1'b1;
            end
        endcase
    end

    assign sum   = {1'b0, lhs} + {1'b0, rhs} + {{DATA_W{1'b0}}, cin};
    assign r     = sum[DATA_W-1:0];
    assign carry = sum[DATA_W];
    assign vflag = (lhs[DATA_W-1] == rhs[DATA_W-1]) && (r[DATA_W-1] != lhs[DATA_W-1]);

    // Overflow of the full-width operations: signed overflow, carry on an
    // unsigned add and borrow on an unsigned subtract.
    assign ovf_wide = sgn ? vflag : ((i_cmd == CMD_ADD) ? carry : !carry);

    // In 32-bit mode the exact result fits when the extended bits agree.
    assign ovf_narrow = sgn ? !((&r[DATA_W-1:HALF_W-1]) || !(|r[DATA_W-1:HALF_W-1]))
                            : ((i_cmd == CMD_ADD) ? r[HALF_W] : r[DATA_W-1]);

    // Magnitudes and product sign feed the multiplier.
    always_comb begin
        o_front.sgn       = sgn;
        o_front.arith_r   = i_is_wide ? r : {{HALF_W{1'b0}}, r[HALF_W-1:0]};
        o_front.arith_ovf = i_is_wide ? ovf_wide : ovf_narrow;
        o_front.mag_a     = (sgn && x[DATA_W-1]) ? (~x + 1'b1) : x;
        o_front.mag_b     = (sgn && y[DATA_W-1]) ? (~y + 1'b1) : y;
        o_front.neg       = sgn && (x[DATA_W-1] ^ y[DATA_W-1]);
    end

endmodule

// File: sv/cia_mul.sv
module cia_mul (
    input  logic                          i_clk,
    input  cia_pkg::t_mul_en              i_en,
    input  logic [cia_pkg::DATA_W-1:0]    i_mag_a,
    input  logic [cia_pkg::DATA_W-1:0]    i_mag_b,
    output logic [cia_pkg::DATA_W-1:0]    o_lo,
    output logic [cia_pkg::DATA_W-1:0]    o_hi
);
    import cia_pkg::*;

    logic [HALF_W-1:0] a0;
    logic [HALF_W-1:0] a1;
    logic [HALF_W-1:0] b0;
    logic [HALF_W-1:0] b1;
    logic [DATA_W-1:0] r_p00;
    logic [DATA_W-1:0] r_p01;
    logic [DATA_W-1:0] r_p10;
    logic [DATA_W-1:0] r_p11;
    logic [HALF_W+1:0] mid;
    logic [DATA_W-1:0] n_lo;
    logic [DATA_W-1:0] n_hi;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_hi;

    assign a0 = i_mag_a[HALF_W-1:0];
    assign a1 = i_mag_a[DATA_W-1:HALF_W];
    assign b0 = i_mag_b[HALF_W-1:0];
    assign b1 = i_mag_b[DATA_W-1:HALF_W];

    // First stage: four 32 x 32 partial products.
    always_ff @(posedge i_clk) begin
        if (i_en.ld_pp) begin
            r_p00 <= DATA_W'(a0) * DATA_W'(b0);
            r_p01 <= DATA_W'(a0) * DATA_W'(b1);
            r_p10 <= DATA_W'(a1) * DATA_W'(b0);
            r_p11 <= DATA_W'(a1) * DATA_W'(b1);
        end
    end

    // Second stage: combine the partial products into the 128-bit product.
    always_comb begin
        mid  = {2'b00, r_p00[DATA_W-1:HALF_W]} + {2'b00, r_p01[HALF_W-1:0]}
             + {2'b00, r_p10[HALF_W-1:0]};
        n_lo = {mid[HALF_W-1:0], r_p00[HALF_W-1:0]};
        n_hi = r_p11 + {{HALF_W{1'b0}}, r_p01[DATA_W-1:HALF_W]}
             + {{HALF_W{1'b0}}, r_p10[DATA_W-1:HALF_W]}
             + {{(DATA_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_sum) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// File: sv/checked_integer_alu_core.sv
// Overflow-checked integer arithmetic unit.
// Input channel: i_in_valid / o_in_stall carry one transaction made of the
// operation code, signedness, width select, two 64-bit operands and a bit
// that clears the sticky overflow flag before the operation is applied.
// Output channel: o_out_valid / i_out_stall carry the wrapped result, this
// transaction's overflow bit and the sticky flag after it.
// A transaction is moved at a rising edge where valid is high and stall low.
// Every operation passes through the same stages. Throughput: one
// transaction per cycle while the receiver does not stall; the 64 x 64
// multiplier is built from 32 x 32 partial products in one stage and
// their sum in the next.
// When the receiver stalls, the result register holds its transaction and
// the pipeline keeps accepting until every stage is full; o_in_stall then
// rises. Each stage holds its own valid bit, so bubbles are squeezed out.
// Reset (synchronous, active low) empties all stages and clears the sticky
// flag; no transaction is lost or repeated across a stall.
module checked_integer_alu_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_cmd,
    input  logic                          i_is_signed,
    input  logic                          i_is_wide,
    input  logic [cia_pkg::DATA_W-1:0]    i_operand_a,
    input  logic [cia_pkg::DATA_W-1:0]    i_operand_b,
    input  logic                          i_clear_sticky,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cia_pkg::DATA_W-1:0]    o_result_bits,
    output logic                          o_op_overflowed,
    output logic                          o_sticky_flag
);
    import cia_pkg::*;

    // Stage valid bits and load enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_v1, n_v2, n_v3, n_v4, n_v5;
    logic ld1, ld2, ld3, ld4, ld5;

    // Input register.
    t_cmd              r_cmd1;
    logic              r_sgn1;
    logic              r_wide1;
    logic              r_clr1;
    logic [DATA_W-1:0] r_a1;
    logic [DATA_W-1:0] r_b1;

    // Later stages.
    t_front            front;
    t_side             n_side2;
    t_side             r_side2;
    t_side             r_side3;
    t_side             r_side4;
    logic [DATA_W-1:0] r_mag_a2;
    logic [DATA_W-1:0] r_mag_b2;
    t_mul_en           mul_en;
    logic [DATA_W-1:0] prod_lo;
    logic [DATA_W-1:0] prod_hi;

    // Result stage.
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] mag_w;
    logic [DATA_W-1:0] lim;
    logic              big;
    logic              mul_ovf;
    logic [DATA_W-1:0] n_res;
    logic              n_ovf;
    logic              n_sticky;
    logic [DATA_W-1:0] r_res;
    logic              r_ovf;
    logic              r_sticky;

    // Each stage loads when it holds nothing or its content moves on.
    always_comb begin
        ld5 = r_v4 && (!r_v5 || !i_out_stall);
        ld4 = r_v3 && (!r_v4 || ld5);
        ld3 = r_v2 && (!r_v3 || ld4);
        ld2 = r_v1 && (!r_v2 || ld3);
        ld1 = i_in_valid && (!r_v1 || ld2);
        n_v1 = ld1 || (r_v1 && !ld2);
        n_v2 = ld2 || (r_v2 && !ld3);
        n_v3 = ld3 || (r_v3 && !ld4);
        n_v4 = ld4 || (r_v4 && !ld5);
        n_v5 = ld5 || (r_v5 && i_out_stall);
    end

    assign o_in_stall = r_v1 && !ld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
            r_v5 <= n_v5;
        end
    end

    // Capture the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_cmd1  <= t_cmd'(i_cmd);
            r_sgn1  <= i_is_signed;
            r_wide1 <= i_is_wide;
            r_clr1  <= i_clear_sticky;
            r_a1    <= i_operand_a;
            r_b1    <= i_operand_b;
        end
    end

    // Operand preparation, add, subtract and negate.
    cia_front u_front (
        .i_cmd       (r_cmd1),
        .i_is_signed (r_sgn1),
        .i_is_wide   (r_wide1),
        .i_operand_a (r_a1),
        .i_operand_b (r_b1),
        .o_front     (front)
    );

    always_comb begin
        n_side2.wide      = r_wide1;
        n_side2.sgn       = front.sgn;
        n_side2.is_mul    = (r_cmd1 == CMD_MUL);
        n_side2.clr       = r_clr1;
        n_side2.arith_r   = front.arith_r;
        n_side2.arith_ovf = front.arith_ovf;
        n_side2.neg       = front.neg;
    end

    // Side fields follow the multiplier stages.
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_side2  <= n_side2;
            r_mag_a2 <= front.mag_a;
            r_mag_b2 <= front.mag_b;
        end
        if (ld3) begin
            r_side3 <= r_side2;
        end
        if (ld4) begin
            r_side4 <= r_side3;
        end
    end

    assign mul_en.ld_pp  = ld3;
    assign mul_en.ld_sum = ld4;

    cia_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (mul_en),
        .i_mag_a (r_mag_a2),
        .i_mag_b (r_mag_b2),
        .o_lo    (prod_lo),
        .o_hi    (prod_hi)
    );

    // Apply the product sign, check the range and update the sticky flag.
    always_comb begin
        prod  = r_side4.neg ? (~prod_lo + 1'b1) : prod_lo;
        big   = r_side4.wide ? (|prod_hi) : (|prod_lo[DATA_W-1:HALF_W]);
        mag_w = r_side4.wide ? prod_lo : {{HALF_W{1'b0}}, prod_lo[HALF_W-1:0]};
        lim   = r_side4.wide ? {1'b1, {(DATA_W-1){1'b0}}}
                             : {{HALF_W{1'b0}}, 1'b1, {(HALF_W-1){1'b0}}};
        if (!r_side4.sgn) begin
            mul_ovf = big;
        end else if (r_side4.neg) begin
            mul_ovf = big || (mag_w > lim);
        end else begin
            mul_ovf = big || (mag_w >= lim);
        end
        if (r_side4.is_mul) begin
            n_res = r_side4.wide ? prod : {{HALF_W{1'b0}}, prod[HALF_W-1:0]};
            n_ovf = mul_ovf;
        end else begin
            n_res = r_side4.arith_r;
            n_ovf = r_side4.arith_ovf;
        end
        n_sticky = (r_sticky && !r_side4.clr) || n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (ld5) begin
            r_res <= n_res;
            r_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else if (ld5) begin
            r_sticky <= n_sticky;
        end
    end

    assign o_out_valid     = r_v5;
    assign o_result_bits   = r_res;
    assign o_op_overflowed = r_ovf;
    assign o_sticky_flag   = r_sticky;

`ifndef NO_ASSERTIONS
    // An overflowing transaction always leaves the sticky flag set.
    a_sticky_covers_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_op_overflowed) |-> o_sticky_flag)
        else $error("sticky flag clear after an overflowing transaction");

    // The sticky flag only drops on reset or when a clearing transaction
    // reaches the output.
    a_sticky_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_sticky) |-> ($past(!i_rst_n) || $past(ld5 && r_side4.clr)))
        else $error("sticky flag dropped without a clear request");

    // A held result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && i_out_stall) |-> !ld5)
        else $error("result register loaded while its transaction was stalled");
`endif

endmodule

// File: sim/checked_integer_alu_checker.sv
// Watches both channels of the overflow-checked integer unit. It predicts each
// result from the accepted input transactions and compares the results that
// come out, in order.
module checked_integer_alu_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [1:0]                 i_cmd,
    input  logic                       i_is_signed,
    input  logic                       i_is_wide,
    input  logic [cia_pkg::DATA_W-1:0] i_operand_a,
    input  logic [cia_pkg::DATA_W-1:0] i_operand_b,
    input  logic                       i_clear_sticky,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [cia_pkg::DATA_W-1:0] i_result_bits,
    input  logic                       i_op_overflowed,
    input  logic                       i_sticky_flag,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    // One result transaction as the block should deliver it.
    typedef struct packed {
        logic [DATA_W-1:0] result_bits;
        logic              op_overflowed;
        logic              sticky_flag;
    } t_alu_outcome;

    t_alu_outcome expected_outcomes[$];
    logic         sticky_model = 1'b0;
    int           mismatch_total = 0;

    // Exact arithmetic on 130-bit signed values, then a range check against
    // the selected width and signedness. The sticky flag is left to the caller.
    function automatic t_alu_outcome compute_outcome(
        input t_cmd              cmd,
        input logic              sgn,
        input logic              wide,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic signed [129:0] x;
        logic signed [129:0] y;
        logic signed [129:0] exact;
        logic signed [129:0] lo_lim;
        logic signed [129:0] hi_lim;
        logic                use_sgn;
        int                  w;
        t_alu_outcome        outcome;

        // Negate always works on two's-complement operands.
        use_sgn = (cmd == CMD_NEG) ? 1'b1 : sgn;
        w       = wide ? DATA_W : HALF_W;

        if (wide) begin
            x = use_sgn ? {{66{a[63]}}, a} : {66'b0, a};
            y = use_sgn ? {{66{b[63]}}, b} : {66'b0, b};
        end else begin
            // In narrow mode the upper operand halves play no part.
            x = use_sgn ? {{98{a[31]}}, a[31:0]} : {98'b0, a[31:0]};
            y = use_sgn ? {{98{b[31]}}, b[31:0]} : {98'b0, b[31:0]};
        end

        case (cmd)
            CMD_ADD: exact = x + y;
            CMD_SUB: exact = x - y;
            CMD_NEG: exact = 130'sd0 - x;
            default: exact = x * y;
        endcase

        if (use_sgn) begin
            hi_lim = (130'sd1 <<< (w - 1)) - 130'sd1;
            lo_lim = 130'sd0 - (130'sd1 <<< (w - 1));
        end else begin
            hi_lim = (130'sd1 <<< w) - 130'sd1;
            lo_lim = 130'sd0;
        end

        outcome.op_overflowed = (exact < lo_lim) || (exact > hi_lim);
        outcome.result_bits   = wide ? exact[63:0] : {32'b0, exact[31:0]};
        outcome.sticky_flag   = 1'b0;
        return outcome;
    endfunction

    // Results are taken before inputs at the same edge; the pipeline latency
    // keeps a result from ever belonging to an input of that very edge.
    always @(posedge i_clk) begin : watch_channels
        t_alu_outcome want;
        t_alu_outcome got;

        if (!i_rst_n) begin
            expected_outcomes.delete();
            sticky_model = 1'b0;
        end else begin
            // Output side: compare against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got.result_bits   = i_result_bits;
                got.op_overflowed = i_op_overflowed;
                got.sticky_flag   = i_sticky_flag;
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result transaction: result_bits %h", got.result_bits);
                    mismatch_total++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.result_bits !== want.result_bits) begin
                        $error("result_bits: expected %h, actual %h",
                               want.result_bits, got.result_bits);
                        mismatch_total++;
                    end
                    if (got.op_overflowed !== want.op_overflowed) begin
                        $error("op_overflowed: expected %b, actual %b",
                               want.op_overflowed, got.op_overflowed);
                        mismatch_total++;
                    end
                    if (got.sticky_flag !== want.sticky_flag) begin
                        $error("sticky_flag: expected %b, actual %b",
                               want.sticky_flag, got.sticky_flag);
                        mismatch_total++;
                    end
                end
            end

            // Input side: clear first, then fold in this overflow.
            if (i_in_valid && !i_in_stall) begin
                if (i_clear_sticky) begin
                    sticky_model = 1'b0;
                end
                want = compute_outcome(t_cmd'(i_cmd), i_is_signed, i_is_wide,
                                       i_operand_a, i_operand_b);
                if (want.op_overflowed) begin
                    sticky_model = 1'b1;
                end
                want.sticky_flag = sticky_model;
                expected_outcomes.push_back(want);
            end
        end

        o_pending    <= expected_outcomes.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// File: sim/checked_integer_alu_core_tb.sv
module checked_integer_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    localparam int ITEMS_PER_PHASE = 220;
    localparam int PHASE_COUNT     = 4;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        cmd          = 2'b0;
    logic              is_signed    = 1'b0;
    logic              is_wide      = 1'b0;
    logic [DATA_W-1:0] operand_a    = '0;
    logic [DATA_W-1:0] operand_b    = '0;
    logic              clear_sticky = 1'b0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DATA_W-1:0] result_bits;
    logic              op_overflowed;
    logic              sticky_flag;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    always #5 clk = ~clk;

    checked_integer_alu_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_is_signed    (is_signed),
        .i_is_wide      (is_wide),
        .i_operand_a    (operand_a),
        .i_operand_b    (operand_b),
        .i_clear_sticky (clear_sticky),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_bits  (result_bits),
        .o_op_overflowed(op_overflowed),
        .o_sticky_flag  (sticky_flag)
    );

    checked_integer_alu_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_is_signed    (is_signed),
        .i_is_wide      (is_wide),
        .i_operand_a    (operand_a),
        .i_operand_b    (operand_b),
        .i_clear_sticky (clear_sticky),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_bits  (result_bits),
        .i_op_overflowed(op_overflowed),
        .i_sticky_flag  (sticky_flag),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hard stop in case a transaction is lost or the handshake hangs.
    initial begin
        #2_000_000;
        $display("checked_integer_alu_core_tb: errors");
        $finish;
    end

    // Operands lean on the width and sign boundaries, with magnitudes of
    // random length so that multiplies land on both sides of overflow.
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] mag;

        mag = {$urandom, $urandom} >> $urandom_range(63);
        case ($urandom_range(11))
            0:       return 64'h0;
            1:       return 64'h1;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF;
            3:       return 64'h8000_0000_0000_0000;
            4:       return 64'h7FFF_FFFF_FFFF_FFFF;
            5:       return {$urandom, 32'h8000_0000};
            6:       return {$urandom, 32'h7FFF_FFFF};
            7:       return {$urandom, 32'hFFFF_FFFF};
            8:       return mag;
            9:       return 64'h0 - mag;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Presents one input transaction after a random gap and returns at the
    // edge where it is accepted. Valid stays high so back-to-back items flow.
    task automatic issue_operation(
        input t_cmd              op,
        input logic              sgn,
        input logic              wide,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic              clr
    );
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        is_signed    <= sgn;
        is_wide      <= wide;
        operand_a    <= a;
        operand_b    <= b;
        clear_sticky <= clr;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic wait_for_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin : stimulus
        int phase;
        int n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: width limits, sign limits and the sticky clear.
        issue_operation(CMD_ADD, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b0);
        issue_operation(CMD_ADD, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 1'b1);
        issue_operation(CMD_ADD, 1'b1, 1'b1, 64'h8000_0000_0000_0000,
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        issue_operation(CMD_ADD, 1'b0, 1'b0, 64'hA5A5_5A5A_FFFF_FFFF,
                        64'h5A5A_A5A5_0000_0001, 1'b0);
        issue_operation(CMD_ADD, 1'b1, 1'b0, 64'h0000_0000_7FFF_FFFF, 64'h1, 1'b0);
        issue_operation(CMD_SUB, 1'b0, 1'b1, 64'h0, 64'h1, 1'b0);
        issue_operation(CMD_SUB, 1'b0, 1'b0, 64'hFFFF_FFFF_0000_0000,
                        64'h0000_0001_0000_0001, 1'b0);
        issue_operation(CMD_SUB, 1'b1, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 1'b0);
        // Subtracting the most negative value from minus one fits.
        issue_operation(CMD_SUB, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'h8000_0000_0000_0000, 1'b1);
        issue_operation(CMD_SUB, 1'b1, 1'b0, 64'h0, 64'h0000_0000_8000_0000, 1'b0);
        // Negate ignores the signedness bit.
        issue_operation(CMD_NEG, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 64'h1, 1'b0);
        issue_operation(CMD_NEG, 1'b1, 1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        issue_operation(CMD_NEG, 1'b0, 1'b0, 64'h1234_5678_8000_0000, 64'h0, 1'b0);
        issue_operation(CMD_NEG, 1'b0, 1'b1, 64'h1, 64'h0, 1'b0);
        // Unsigned multiply overflows on any product beyond the width.
        issue_operation(CMD_MUL, 1'b0, 1'b1, 64'h1_0000_0000, 64'h1_0000_0000, 1'b0);
        issue_operation(CMD_MUL, 1'b0, 1'b1, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b1);
        issue_operation(CMD_MUL, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 64'h2, 1'b0);
        issue_operation(CMD_MUL, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 64'h1, 1'b1);
        issue_operation(CMD_MUL, 1'b1, 1'b1, 64'h8000_0000_0000_0000,
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        issue_operation(CMD_MUL, 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0000, 64'h1_0000_0000, 1'b1);
        issue_operation(CMD_MUL, 1'b1, 1'b1, 64'h8000_0000, 64'h1_0000_0000, 1'b0);
        issue_operation(CMD_MUL, 1'b0, 1'b0, 64'h1_0001_0000, 64'h0001_0000, 1'b0);
        issue_operation(CMD_MUL, 1'b1, 1'b0, 64'h8000, 64'h1_0000, 1'b0);
        issue_operation(CMD_MUL, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_8000, 64'h1_0000, 1'b1);
        issue_operation(CMD_ADD, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        wait_for_results_drained();

        // Random phases: free flow, sender gaps, receiver stalls, then both.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 55; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 55; end
                default: begin idle_pct = 31; stall_pct <= 31; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                issue_operation(t_cmd'($urandom_range(3)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), pick_operand(), pick_operand(),
                                ($urandom_range(7) == 0));
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_for_results_drained();
                end
            end
        end

        // Let the pipeline empty, then wait for any stray results.
        wait_for_results_drained();
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("checked_integer_alu_core_tb: clean");
        end else begin
            $display("checked_integer_alu_core_tb: errors");
        end
        $finish;
    end

endmodule
